// ----- hw/rtl/trp_pkg.sv -----
package trp_pkg;

    localparam int TIME_BITS_DEF    = 32;
    localparam int CURRENT_BITS_DEF = 22;
    localparam int PADDR_W          = 5;
    localparam int PDATA_W          = 32;
    localparam int ITEM_FIXED_W     = 32;

    localparam logic [31:0] STALE_AFTER_RST     = 32'd300000;
    localparam logic [31:0] REPORT_INTERVAL_RST = 32'd900000;
    localparam logic [31:0] MIN_SEND_RST        = 32'd60000;
    localparam logic [9:0]  SOC_DELTA_RST       = 10'd10;
    localparam logic [14:0] VOLT_STEP_RST       = 15'd5;
    localparam logic [21:0] CUR_STEP_RST        = 22'd500;
    localparam logic [9:0]  LOW_SOC_RST         = 10'd200;
    localparam logic [9:0]  REARM_SOC_RST       = 10'd300;

    typedef enum logic [2:0] {
        REG_STALE_AFTER     = 3'd0,
        REG_REPORT_INTERVAL = 3'd1,
        REG_MIN_SEND        = 3'd2,
        REG_SOC_DELTA       = 3'd3,
        REG_VOLT_STEP       = 3'd4,
        REG_CUR_STEP        = 3'd5,
        REG_LOW_SOC         = 3'd6,
        REG_REARM_SOC       = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_FIRST    = 2'd1,
        CAUSE_PERIODIC = 2'd2,
        CAUSE_CHANGE   = 2'd3
    } t_cause;

    typedef struct packed {
        logic [31:0] stale_limit;
        logic [31:0] report_interval_ms;
        logic [31:0] min_gap;
        logic [9:0]  soc_delta;
        logic [14:0] volt_step;
        logic [21:0] cur_step;
        logic [9:0]  low_soc_level;
        logic [9:0]  rearm_soc_level;
    } t_cfg;

endpackage

// ----- hw/rtl/telemetry_report_policy.sv -----
// Reporting policy for one battery telemetry source.
// Input channel (i_in_valid / o_in_ready): one transaction per evaluation tick,
// carrying the current time, the latest reading and the two send gates.
// Output channel (o_out_valid / i_out_ready): one transaction per input
// transaction, in order: fresh flag, alarm request, report request and cause.
// Configuration: APB-style port, eight 32-bit registers at byte offsets 4*i;
// write only while no transaction is in flight.
// Path: an input transaction is written into the queue, and the back stage
// reads the queue and loads the output register with the result.
// Throughput: one transaction per cycle while i_out_ready is high; the policy
// state is read and updated in the cycle when the back stage pops the queue.
// Stall: when i_out_ready is low the output register holds, the two-entry
// queue between front and back fills, and o_in_ready drops when it is full.
// Reset (synchronous, i_rst_n low): registers return to their defaults, the
// queue and output register empty, and the send and alarm history clears.
module telemetry_report_policy #(
    parameter int TIME_BITS    = trp_pkg::TIME_BITS_DEF,
    parameter int CURRENT_BITS = trp_pkg::CURRENT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trp_pkg::PADDR_W-1:0]   paddr,
    input  logic [trp_pkg::PDATA_W-1:0]   pwdata,
    output logic [trp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [TIME_BITS-1:0]          i_now_ms,
    input  logic [TIME_BITS-1:0]          i_received_ms,
    input  logic                          i_reading_valid,
    input  logic                          i_has_soc,
    input  logic [9:0]                    i_soc_tenths,
    input  logic                          i_has_volt,
    input  logic signed [15:0]            i_voltage_cv,
    input  logic                          i_has_current,
    input  logic signed [CURRENT_BITS-1:0] i_current_ma,
    input  logic                          i_report_ok,
    input  logic                          i_alert_ok,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_fresh,
    output logic                          o_alert_request,
    output logic                          o_report_request,
    output logic [1:0]                    o_report_cause
);

    localparam int ITEM_W = TIME_BITS + CURRENT_BITS + trp_pkg::ITEM_FIXED_W;

    trp_pkg::t_cfg     w_cfg;
    logic              w_q_valid;
    logic [ITEM_W-1:0] w_q_item;
    logic              w_q_pop;

    trp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    trp_front #(
        .TIME_BITS    (TIME_BITS),
        .CURRENT_BITS (CURRENT_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_stale_limit    (w_cfg.stale_limit),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_now_ms         (i_now_ms),
        .i_received_ms    (i_received_ms),
        .i_reading_valid  (i_reading_valid),
        .i_has_soc        (i_has_soc),
        .i_soc_tenths     (i_soc_tenths),
        .i_has_volt       (i_has_volt),
        .i_voltage_cv     (i_voltage_cv),
        .i_has_current    (i_has_current),
        .i_current_ma     (i_current_ma),
        .i_report_ok      (i_report_ok),
        .i_alert_ok       (i_alert_ok),
        .o_q_valid        (w_q_valid),
        .o_q_item         (w_q_item),
        .i_q_pop          (w_q_pop)
    );

    trp_back #(
        .TIME_BITS    (TIME_BITS),
        .CURRENT_BITS (CURRENT_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_q_valid        (w_q_valid),
        .i_q_item         (w_q_item),
        .o_q_pop          (w_q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_fresh          (o_fresh),
        .o_alert_request  (o_alert_request),
        .o_report_request (o_report_request),
        .o_report_cause   (o_report_cause)
    );

endmodule

// ----- hw/rtl/trp_cfg.sv -----
module trp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trp_pkg::PADDR_W-1:0]   paddr,
    input  logic [trp_pkg::PDATA_W-1:0]   pwdata,
    output logic [trp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output trp_pkg::t_cfg                 o_cfg
);

    trp_pkg::t_cfg r_cfg;
    trp_pkg::t_reg w_idx;
    logic          w_wr;

    assign w_idx  = trp_pkg::t_reg'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stale_limit          <= trp_pkg::STALE_AFTER_RST;
            r_cfg.report_interval_ms   <= trp_pkg::REPORT_INTERVAL_RST;
            r_cfg.min_gap              <= trp_pkg::MIN_SEND_RST;
            r_cfg.soc_delta            <= trp_pkg::SOC_DELTA_RST;
            r_cfg.volt_step            <= trp_pkg::VOLT_STEP_RST;
            r_cfg.cur_step             <= trp_pkg::CUR_STEP_RST;
            r_cfg.low_soc_level        <= trp_pkg::LOW_SOC_RST;
            r_cfg.rearm_soc_level      <= trp_pkg::REARM_SOC_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                trp_pkg::REG_STALE_AFTER:     r_cfg.stale_limit          <= pwdata;
                trp_pkg::REG_REPORT_INTERVAL: r_cfg.report_interval_ms   <= pwdata;
                trp_pkg::REG_MIN_SEND:        r_cfg.min_gap              <= pwdata;
                trp_pkg::REG_SOC_DELTA:       r_cfg.soc_delta            <= pwdata[9:0];
                trp_pkg::REG_VOLT_STEP:       r_cfg.volt_step            <= pwdata[14:0];
                trp_pkg::REG_CUR_STEP:        r_cfg.cur_step             <= pwdata[21:0];
                trp_pkg::REG_LOW_SOC:         r_cfg.low_soc_level        <= pwdata[9:0];
                trp_pkg::REG_REARM_SOC:       r_cfg.rearm_soc_level      <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            trp_pkg::REG_STALE_AFTER:     prdata = r_cfg.stale_limit;
            trp_pkg::REG_REPORT_INTERVAL: prdata = r_cfg.report_interval_ms;
            trp_pkg::REG_MIN_SEND:        prdata = r_cfg.min_gap;
            trp_pkg::REG_SOC_DELTA:       prdata = {22'd0, r_cfg.soc_delta};
            trp_pkg::REG_VOLT_STEP:       prdata = {17'd0, r_cfg.volt_step};
            trp_pkg::REG_CUR_STEP:        prdata = {10'd0, r_cfg.cur_step};
            trp_pkg::REG_LOW_SOC:         prdata = {22'd0, r_cfg.low_soc_level};
            trp_pkg::REG_REARM_SOC:       prdata = {22'd0, r_cfg.rearm_soc_level};
            default:                      prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/trp_front.sv -----
module trp_front #(
    parameter int TIME_BITS    = trp_pkg::TIME_BITS_DEF,
    parameter int CURRENT_BITS = trp_pkg::CURRENT_BITS_DEF,
    localparam int ITEM_W      = TIME_BITS + CURRENT_BITS + trp_pkg::ITEM_FIXED_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [31:0]             i_stale_limit,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [TIME_BITS-1:0]    i_now_ms,
    input  logic [TIME_BITS-1:0]    i_received_ms,
    input  logic                    i_reading_valid,
    input  logic                    i_has_soc,
    input  logic [9:0]              i_soc_tenths,
    input  logic                    i_has_volt,
    input  logic signed [15:0]      i_voltage_cv,
    input  logic                    i_has_current,
    input  logic signed [CURRENT_BITS-1:0] i_current_ma,
    input  logic                    i_report_ok,
    input  logic                    i_alert_ok,
    output logic                    o_q_valid,
    output logic [ITEM_W-1:0]       o_q_item,
    input  logic                    i_q_pop
);

    typedef struct packed {
        logic                    fresh;
        logic [TIME_BITS-1:0]    now;
        logic                    has_soc;
        logic [9:0]              soc;
        logic                    has_v;
        logic [15:0]             v;
        logic                    has_c;
        logic [CURRENT_BITS-1:0] c;
        logic                    report_ok;
        logic                    alert_ok;
    } t_item;

    t_item                r_q [2];
    logic                 r_wr;
    logic                 r_rd;
    logic [1:0]           r_cnt;
    t_item                w_item;
    logic [TIME_BITS-1:0] w_age;
    logic                 w_push;

    assign w_age = i_now_ms - i_received_ms;

    always_comb begin
        w_item.fresh     = i_reading_valid & (64'(w_age) <= 64'(i_stale_limit));
        w_item.now       = i_now_ms;
        w_item.has_soc   = i_has_soc;
        w_item.soc       = i_soc_tenths;
        w_item.has_v     = i_has_volt;
        w_item.v         = i_voltage_cv;
        w_item.has_c     = i_has_current;
        w_item.c         = i_current_ma;
        w_item.report_ok = i_report_ok;
        w_item.alert_ok  = i_alert_ok;
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign w_push     = i_in_valid & o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

endmodule

// ----- hw/rtl/trp_back.sv -----
module trp_back #(
    parameter int TIME_BITS    = trp_pkg::TIME_BITS_DEF,
    parameter int CURRENT_BITS = trp_pkg::CURRENT_BITS_DEF,
    localparam int ITEM_W      = TIME_BITS + CURRENT_BITS + trp_pkg::ITEM_FIXED_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trp_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    input  logic [ITEM_W-1:0]   i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_fresh,
    output logic                o_alert_request,
    output logic                o_report_request,
    output logic [1:0]          o_report_cause
);

    typedef struct packed {
        logic                    fresh;
        logic [TIME_BITS-1:0]    now;
        logic                    has_soc;
        logic [9:0]              soc;
        logic                    has_v;
        logic [15:0]             v;
        logic                    has_c;
        logic [CURRENT_BITS-1:0] c;
        logic                    report_ok;
        logic                    alert_ok;
    } t_item;

    t_item                   w_it;
    logic                    r_sent;
    logic [TIME_BITS-1:0]    r_last;
    logic                    r_latched;
    logic                    r_pub_valid;
    logic                    r_pub_has_soc;
    logic [9:0]              r_pub_soc;
    logic                    r_pub_has_v;
    logic [15:0]             r_pub_v;
    logic                    r_pub_has_c;
    logic [CURRENT_BITS-1:0] r_pub_c;
    logic                    r_out_valid;
    logic                    r_fresh;
    logic                    r_alert;
    logic                    r_report;
    trp_pkg::t_cause         r_cause;

    logic [9:0]              w_dsoc;
    logic signed [16:0]      w_dv;
    logic [15:0]             w_adv;
    logic signed [CURRENT_BITS:0] w_dc;
    logic [CURRENT_BITS-1:0] w_adc;
    logic [TIME_BITS-1:0]    w_since;
    logic                    w_per_el;
    logic                    w_min_el;
    logic                    w_change;
    logic                    w_alert;
    logic                    w_publish;
    trp_pkg::t_cause         w_cause;

    assign w_it    = t_item'(i_q_item);
    assign o_q_pop = i_q_valid & (~r_out_valid | i_out_ready);

    assign w_dsoc  = (w_it.soc >= r_pub_soc) ? w_it.soc - r_pub_soc : r_pub_soc - w_it.soc;
    assign w_dv    = 17'(signed'(w_it.v)) - 17'(signed'(r_pub_v));
    assign w_adv   = w_dv[16] ? 16'(-w_dv) : w_dv[15:0];
    assign w_dc    = (CURRENT_BITS+1)'(signed'(w_it.c)) - (CURRENT_BITS+1)'(signed'(r_pub_c));
    assign w_adc   = w_dc[CURRENT_BITS] ? CURRENT_BITS'(-w_dc) : w_dc[CURRENT_BITS-1:0];
    assign w_since = w_it.now - r_last;
    assign w_per_el = 64'(w_since) >= 64'(i_cfg.report_interval_ms);
    assign w_min_el = 64'(w_since) >= 64'(i_cfg.min_gap);

    always_comb begin
        w_change = ~r_pub_valid
            | (w_it.has_soc & r_pub_has_soc & (w_dsoc >= i_cfg.soc_delta))
            | (w_it.has_v & r_pub_has_v & (w_adv >= {1'b0, i_cfg.volt_step}))
            | (w_it.has_c & r_pub_has_c & (33'(w_adc) >= 33'(i_cfg.cur_step)))
            | (w_it.has_soc ^ r_pub_has_soc)
            | (w_it.has_v ^ r_pub_has_v)
            | (w_it.has_c ^ r_pub_has_c);
        if (!w_it.fresh) begin
            w_cause = trp_pkg::CAUSE_NONE;
        end else if (!r_sent) begin
            w_cause = trp_pkg::CAUSE_FIRST;
        end else if (w_per_el) begin
            w_cause = trp_pkg::CAUSE_PERIODIC;
        end else if (w_change && w_min_el) begin
            w_cause = trp_pkg::CAUSE_CHANGE;
        end else begin
            w_cause = trp_pkg::CAUSE_NONE;
        end
        w_alert   = w_it.fresh & w_it.has_soc & ~r_latched
                    & (w_it.soc <= i_cfg.low_soc_level);
        w_publish = (w_cause != trp_pkg::CAUSE_NONE) & w_it.report_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent        <= 1'b0;
            r_last        <= '0;
            r_latched     <= 1'b0;
            r_pub_valid   <= 1'b0;
            r_pub_has_soc <= 1'b0;
            r_pub_soc     <= '0;
            r_pub_has_v   <= 1'b0;
            r_pub_v       <= '0;
            r_pub_has_c   <= 1'b0;
            r_pub_c       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                if (w_it.fresh & w_it.has_soc) begin
                    if (r_latched && (w_it.soc >= i_cfg.rearm_soc_level)) begin
                        r_latched <= 1'b0;
                    end else if (w_alert && w_it.alert_ok) begin
                        r_latched <= 1'b1;
                    end
                end
                if (w_publish) begin
                    r_sent        <= 1'b1;
                    r_last        <= w_it.now;
                    r_pub_valid   <= 1'b1;
                    r_pub_has_soc <= w_it.has_soc;
                    r_pub_soc     <= w_it.soc;
                    r_pub_has_v   <= w_it.has_v;
                    r_pub_v       <= w_it.v;
                    r_pub_has_c   <= w_it.has_c;
                    r_pub_c       <= w_it.c;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_fresh  <= w_it.fresh;
            r_alert  <= w_alert;
            r_report <= (w_cause != trp_pkg::CAUSE_NONE);
            r_cause  <= w_cause;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_fresh          = r_fresh;
    assign o_alert_request  = r_alert;
    assign o_report_request = r_report;
    assign o_report_cause   = r_cause;

endmodule

// ----- tb/sv/telemetry_report_policy_test.sv -----
`timescale 1ns / 100ps

module telemetry_report_policy_test;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic [31:0]        now;
        logic [31:0]        received;
        logic               reading_valid;
        logic               has_soc;
        logic [9:0]         soc;
        logic               has_volt;
        logic signed [15:0] voltage;
        logic               has_current;
        logic signed [21:0] current;
        logic               report_ok;
        logic               alert_ok;
    } t_tick;

    typedef struct {
        logic       fresh;
        logic       alert;
        logic       report;
        logic [1:0] cause;
    } t_verdict;

    class t_decisions;
        logic [31:0]        stale_after;
        logic [31:0]        report_interval;
        logic [31:0]        min_send;
        logic [9:0]         soc_delta;
        logic [14:0]        volt_step;
        logic [21:0]        cur_step;
        logic [9:0]         low_soc;
        logic [9:0]         rearm_soc;
        bit                 sent_before;
        bit                 alarm_latched;
        logic [31:0]        last_send;
        bit                 pub_valid;
        bit                 pub_has_soc;
        bit                 pub_has_volt;
        bit                 pub_has_current;
        logic [9:0]         pub_soc;
        logic signed [15:0] pub_voltage;
        logic signed [21:0] pub_current;
        t_verdict           awaited[$];
        int                 errors;

        function new();
            stale_after     = trp_pkg::STALE_AFTER_RST;
            report_interval = trp_pkg::REPORT_INTERVAL_RST;
            min_send        = trp_pkg::MIN_SEND_RST;
            soc_delta       = trp_pkg::SOC_DELTA_RST;
            volt_step       = trp_pkg::VOLT_STEP_RST;
            cur_step        = trp_pkg::CUR_STEP_RST;
            low_soc         = trp_pkg::LOW_SOC_RST;
            rearm_soc       = trp_pkg::REARM_SOC_RST;
            sent_before     = 1'b0;
            alarm_latched   = 1'b0;
            last_send       = '0;
            pub_valid       = 1'b0;
            pub_has_soc     = 1'b0;
            pub_has_volt    = 1'b0;
            pub_has_current = 1'b0;
            pub_soc         = '0;
            pub_voltage     = '0;
            pub_current     = '0;
            errors          = 0;
        endfunction

        function void write_reg(trp_pkg::t_reg r, logic [31:0] value);
            case (r)
                trp_pkg::REG_STALE_AFTER:     stale_after = value;
                trp_pkg::REG_REPORT_INTERVAL: report_interval = value;
                trp_pkg::REG_MIN_SEND:        min_send = value;
                trp_pkg::REG_SOC_DELTA:       soc_delta = value[9:0];
                trp_pkg::REG_VOLT_STEP:       volt_step = value[14:0];
                trp_pkg::REG_CUR_STEP:        cur_step = value[21:0];
                trp_pkg::REG_LOW_SOC:         low_soc = value[9:0];
                trp_pkg::REG_REARM_SOC:       rearm_soc = value[9:0];
                default: ;
            endcase
        endfunction

        function bit moved(longint a, longint b, longint delta);
            longint d;
            d = a - b;
            if (d < 0) d = -d;
            return d >= delta;
        endfunction

        function void take_tick(t_tick t);
            t_verdict    v;
            logic [31:0] age;
            logic [31:0] since_send;
            bit          change;
            bit          first;
            bit          periodic;
            v.fresh  = 1'b0;
            v.alert  = 1'b0;
            v.report = 1'b0;
            v.cause  = trp_pkg::CAUSE_NONE;
            age = t.now - t.received;
            since_send = t.now - last_send;
            v.fresh = t.reading_valid && (age <= stale_after);
            if (v.fresh) begin
                if (t.has_soc) begin
                    if (alarm_latched && t.soc >= rearm_soc) begin
                        alarm_latched = 1'b0;
                    end else if (!alarm_latched && t.soc <= low_soc) begin
                        v.alert = 1'b1;
                        if (t.alert_ok) alarm_latched = 1'b1;
                    end
                end
                if (!pub_valid) begin
                    change = 1'b1;
                end else begin
                    change = (t.has_soc && pub_has_soc
                            && moved(longint'(t.soc), longint'(pub_soc),
                                     longint'(soc_delta)))
                        || (t.has_volt && pub_has_volt
                            && moved(longint'(t.voltage), longint'(pub_voltage),
                                     longint'(volt_step)))
                        || (t.has_current && pub_has_current
                            && moved(longint'(t.current), longint'(pub_current),
                                     longint'(cur_step)))
                        || (t.has_soc != pub_has_soc)
                        || (t.has_volt != pub_has_volt)
                        || (t.has_current != pub_has_current);
                end
                first = !sent_before;
                periodic = !first && (since_send >= report_interval);
                change = change && (first || since_send >= min_send);
                if (first) v.cause = trp_pkg::CAUSE_FIRST;
                else if (periodic) v.cause = trp_pkg::CAUSE_PERIODIC;
                else if (change) v.cause = trp_pkg::CAUSE_CHANGE;
                v.report = (v.cause != trp_pkg::CAUSE_NONE);
                if (v.report && t.report_ok) begin
                    sent_before     = 1'b1;
                    last_send       = t.now;
                    pub_valid       = 1'b1;
                    pub_has_soc     = t.has_soc;
                    pub_soc         = t.soc;
                    pub_has_volt    = t.has_volt;
                    pub_voltage     = t.voltage;
                    pub_has_current = t.has_current;
                    pub_current     = t.current;
                end
            end
            awaited.push_back(v);
        endfunction

        function void flag_field(string field, logic [1:0] want, logic [1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void match_result(t_verdict got);
            t_verdict want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with none awaited, expected nothing, actual %0b%0b%0b/%0d",
                         $time, got.fresh, got.alert, got.report, got.cause);
                return;
            end
            want = awaited.pop_front();
            if (got.fresh !== want.fresh)
                flag_field("fresh", {1'b0, want.fresh}, {1'b0, got.fresh});
            if (got.alert !== want.alert)
                flag_field("alert_request", {1'b0, want.alert}, {1'b0, got.alert});
            if (got.report !== want.report)
                flag_field("report_request", {1'b0, want.report}, {1'b0, got.report});
            if (got.cause !== want.cause) flag_field("report_cause", want.cause, got.cause);
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [trp_pkg::PADDR_W-1:0]   paddr;
    logic [trp_pkg::PDATA_W-1:0]   pwdata;
    logic [trp_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [31:0]                   i_now_ms;
    logic [31:0]                   i_received_ms;
    logic                          i_reading_valid;
    logic                          i_has_soc;
    logic [9:0]                    i_soc_tenths;
    logic                          i_has_volt;
    logic signed [15:0]            i_voltage_cv;
    logic                          i_has_current;
    logic signed [21:0]            i_current_ma;
    logic                          i_report_ok;
    logic                          i_alert_ok;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_fresh;
    logic                          o_alert_request;
    logic                          o_report_request;
    logic [1:0]                    o_report_cause;

    t_decisions      decisions;
    int              idle_cycles = 0;
    bit              hold_pending = 1'b0;
    bit              calm = 1'b0;
    logic [31:0]     clock_ms;
    int unsigned     step_max;
    int              walk_soc;
    int              walk_volt;
    int              walk_cur;
    bit              walk_hs;
    bit              walk_hv;
    bit              walk_hc;

    telemetry_report_policy dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_now_ms         (i_now_ms),
        .i_received_ms    (i_received_ms),
        .i_reading_valid  (i_reading_valid),
        .i_has_soc        (i_has_soc),
        .i_soc_tenths     (i_soc_tenths),
        .i_has_volt       (i_has_volt),
        .i_voltage_cv     (i_voltage_cv),
        .i_has_current    (i_has_current),
        .i_current_ma     (i_current_ma),
        .i_report_ok      (i_report_ok),
        .i_alert_ok       (i_alert_ok),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_fresh          (o_fresh),
        .o_alert_request  (o_alert_request),
        .o_report_request (o_report_request),
        .o_report_cause   (o_report_cause)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        t_tick    seen;
        t_verdict got;
        bit       took_in;
        bit       gave_out;
        took_in  = i_rst_n && i_in_valid && o_in_ready === 1'b1;
        gave_out = i_rst_n && o_out_valid === 1'b1 && i_out_ready;
        if (took_in) begin
            seen.now           = i_now_ms;
            seen.received      = i_received_ms;
            seen.reading_valid = i_reading_valid;
            seen.has_soc       = i_has_soc;
            seen.soc           = i_soc_tenths;
            seen.has_volt      = i_has_volt;
            seen.voltage       = i_voltage_cv;
            seen.has_current   = i_has_current;
            seen.current       = i_current_ma;
            seen.report_ok     = i_report_ok;
            seen.alert_ok      = i_alert_ok;
            decisions.take_tick(seen);
        end
        if (gave_out) begin
            got.fresh  = o_fresh;
            got.alert  = o_alert_request;
            got.report = o_report_request;
            got.cause  = o_report_cause;
            decisions.match_result(got);
        end
        if (took_in || gave_out) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        do @(posedge i_clk); while (idle_cycles < STALL_LIMIT);
        $display("telemetry_report_policy verification failed");
        $finish;
    end

    initial begin : sink
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_tick make_tick(logic [31:0] now, logic [31:0] age, int valid,
                                        int hs, int soc, int hv, int volt, int hc,
                                        int cur, int rok, int aok);
        t_tick t;
        t.now           = now;
        t.received      = now - age;
        t.reading_valid = valid[0];
        t.has_soc       = hs[0];
        t.soc           = soc[9:0];
        t.has_volt      = hv[0];
        t.voltage       = volt[15:0];
        t.has_current   = hc[0];
        t.current       = cur[21:0];
        t.report_ok     = rok[0];
        t.alert_ok      = aok[0];
        return t;
    endfunction

    function automatic t_tick random_tick();
        t_tick       t;
        logic [31:0] age;
        if ($urandom_range(0, 9) == 0) begin
            t.now           = $urandom;
            t.received      = $urandom;
            t.reading_valid = 1'($urandom);
            t.has_soc       = 1'($urandom);
            t.soc           = 10'($urandom);
            t.has_volt      = 1'($urandom);
            t.voltage       = 16'($urandom);
            t.has_current   = 1'($urandom);
            t.current       = 22'($urandom);
            t.report_ok     = 1'($urandom);
            t.alert_ok      = 1'($urandom);
            return t;
        end
        clock_ms += $urandom_range(0, step_max);
        case ($urandom_range(0, 5))
            0: age = '0;
            1: age = decisions.stale_after + $urandom_range(0, 2) - 1;
            2: age = $urandom;
            default: age = $urandom_range(0, 3000);
        endcase
        if ($urandom_range(0, 19) == 0) walk_soc = $urandom_range(0, 1000);
        else walk_soc += int'($urandom_range(0, 60)) - 30;
        if (walk_soc < 0) walk_soc = 0;
        if (walk_soc > 1000) walk_soc = 1000;
        if ($urandom_range(0, 19) == 0) walk_volt = int'($urandom_range(0, 65535)) - 32768;
        else walk_volt += int'($urandom_range(0, 16)) - 8;
        if ($urandom_range(0, 19) == 0) walk_cur = int'($urandom_range(0, 4194303)) - 2097152;
        else walk_cur += int'($urandom_range(0, 1600)) - 800;
        if ($urandom_range(0, 11) == 0) walk_hs = !walk_hs;
        if ($urandom_range(0, 11) == 0) walk_hv = !walk_hv;
        if ($urandom_range(0, 11) == 0) walk_hc = !walk_hc;
        return make_tick(clock_ms, age, int'($urandom_range(0, 24) != 0), int'(walk_hs),
                         walk_soc, int'(walk_hv), walk_volt, int'(walk_hc),
                         walk_cur, int'($urandom_range(0, 3) != 0),
                         int'($urandom_range(0, 3) != 0));
    endfunction

    task automatic send(t_tick t);
        i_now_ms        <= t.now;
        i_received_ms   <= t.received;
        i_reading_valid <= t.reading_valid;
        i_has_soc       <= t.has_soc;
        i_soc_tenths    <= t.soc;
        i_has_volt      <= t.has_volt;
        i_voltage_cv    <= t.voltage;
        i_has_current   <= t.has_current;
        i_current_ma    <= t.current;
        i_report_ok     <= t.report_ok;
        i_alert_ok      <= t.alert_ok;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic pause_sender(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (decisions.awaited.size() != 0);
    endtask

    task automatic run_random(int count, bit gaps);
        repeat (count) begin
            send(random_tick());
            if (gaps && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 9));
        end
    endtask

    // leaves the bus in the access phase; configure returns it to idle
    task automatic write_reg(trp_pkg::t_reg r, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        decisions.write_reg(r, value);
    endtask

    task automatic configure(logic [31:0] stale, logic [31:0] interval,
                             logic [31:0] min_gap, logic [31:0] soc_d,
                             logic [31:0] volt_d, logic [31:0] cur_d,
                             logic [31:0] low, logic [31:0] rearm);
        write_reg(trp_pkg::REG_STALE_AFTER, stale);
        write_reg(trp_pkg::REG_REPORT_INTERVAL, interval);
        write_reg(trp_pkg::REG_MIN_SEND, min_gap);
        write_reg(trp_pkg::REG_SOC_DELTA, soc_d);
        write_reg(trp_pkg::REG_VOLT_STEP, volt_d);
        write_reg(trp_pkg::REG_CUR_STEP, cur_d);
        write_reg(trp_pkg::REG_LOW_SOC, low);
        write_reg(trp_pkg::REG_REARM_SOC, rearm);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_config();
        configure($urandom_range(1000, 50000), $urandom_range(5000, 100000),
                  $urandom_range(500, 20000), $urandom_range(0, 60),
                  $urandom_range(0, 40), $urandom_range(0, 3000),
                  $urandom_range(0, 1000), $urandom_range(0, 1000));
    endtask

    initial begin : stimulus
        decisions       = new();
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_in_valid      = 1'b0;
        i_now_ms        = '0;
        i_received_ms   = '0;
        i_reading_valid = 1'b0;
        i_has_soc       = 1'b0;
        i_soc_tenths    = '0;
        i_has_volt      = 1'b0;
        i_voltage_cv    = '0;
        i_has_current   = 1'b0;
        i_current_ma    = '0;
        i_report_ok     = 1'b0;
        i_alert_ok      = 1'b0;
        clock_ms        = 32'd2000000;
        step_max        = 5000;
        walk_soc        = 500;
        walk_volt       = 1300;
        walk_cur        = 0;
        walk_hs         = 1'b1;
        walk_hv         = 1'b1;
        walk_hc         = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values
        send(make_tick(1000, 0, 0, 1, 500, 1, 1200, 1, -100, 1, 1));
        send(make_tick(2000000, 300001, 1, 1, 500, 1, 1200, 1, -100, 1, 1));
        send(make_tick(50, 356, 1, 1, 150, 1, 1200, 1, -100, 0, 0));
        send(make_tick(1000, 300000, 1, 1, 150, 1, 1200, 1, -100, 1, 1));
        send(make_tick(2000, 0, 1, 1, 100, 1, 1200, 1, -100, 1, 1));
        send(make_tick(61000, 10, 1, 1, 100, 1, 1200, 1, -100, 1, 1));
        send(make_tick(62000, 0, 1, 1, 300, 1, 1200, 1, -100, 1, 1));
        send(make_tick(63000, 0, 1, 1, 200, 1, 1200, 1, -100, 1, 1));
        send(make_tick(130000, 0, 1, 1, 200, 0, 1200, 1, -100, 1, 1));
        send(make_tick(1030000, 0, 1, 1, 205, 1, 1200, 1, -100, 1, 1));
        send(make_tick(1100000, 0, 1, 1, 205, 1, 1204, 1, -100, 1, 1));
        send(make_tick(1100001, 0, 1, 1, 205, 1, 1205, 1, -100, 0, 1));
        send(make_tick(1100002, 0, 1, 1, 205, 1, 1200, 1, 400, 1, 1));
        send(make_tick(1200000, 0, 1, 1, 205, 1, 1200, 1, -2097152, 1, 1));
        send(make_tick(1300000, 0, 1, 1, 205, 1, -32768, 1, 2097151, 1, 1));
        send(make_tick(1400000, 0, 1, 1, 1023, 1, 32767, 1, 2097151, 1, 1));
        send(make_tick(1500000, 0, 1, 1, 0, 1, 32767, 1, 2097151, 1, 0));
        send(make_tick(1500500, 0, 1, 0, 0, 1, 32767, 1, 2097151, 1, 1));
        send(make_tick(32'hFFFF_FFF0, 0, 1, 0, 0, 1, 32767, 1, 2097151, 1, 1));
        send(make_tick(32'h0000_0100, 0, 1, 0, 0, 1, 32767, 1, 2097151, 1, 1));
        send(make_tick(60300, 0, 1, 0, 0, 1, 32767, 0, 2097151, 1, 1));

        drain();
        random_config();
        run_random(150, 1'b1);

        drain();
        configure('0, '0, '0, '0, '0, '0, '0, '0);
        step_max = 200;
        run_random(60, 1'b1);

        drain();
        configure('1, '1, '1, '1, '1, '1, '1, '1);
        step_max = 32'h8000_0000;
        clock_ms = 32'hFFF0_0000;
        run_random(60, 1'b1);

        drain();
        random_config();
        step_max = 5000;
        // hold off the output side while offering back to back
        hold_pending = 1'b1;
        run_random(30, 1'b0);
        run_random(120, 1'b1);
        calm = 1'b1;
        run_random(80, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (decisions.errors == 0 && decisions.awaited.size() == 0)
            $display("telemetry_report_policy verification clean");
        else
            $display("telemetry_report_policy verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/trp_pkg.sv
hw/rtl/trp_cfg.sv
hw/rtl/trp_front.sv
hw/rtl/trp_back.sv
hw/rtl/telemetry_report_policy.sv
tb/sv/telemetry_report_policy_test.sv
